FILE: rtl/core/fecc_pkg.sv
// Package for the flat-end cubic coefficient solver.
// Holds the widths, the result codes and the per-cell record shared by all modules.
`default_nettype none

package fecc_pkg;

    // Fixed-point and coordinate format.
    localparam int FRAC_BITS  = 40;
    localparam int COORD_BITS = 16;
    localparam int COEF_W     = 64;
    localparam int LANES      = 4;
    localparam int CELLS      = COEF_W;

    // Derived widths of the numerator path.
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int TRI_W    = COORD_BITS + 3;
    localparam int ABS_W    = COORD_BITS;
    localparam int SQ_W     = 2 * COORD_BITS;
    localparam int DSQ_W    = 2 * DIFF_W;
    localparam int DEN_W    = 3 * ABS_W;
    localparam int PROD_W   = DIFF_W + SQ_W;
    localparam int YD_W     = COORD_BITS + DEN_W + 1;
    localparam int NUM_W    = 4 * COORD_BITS + 4;
    localparam int LOW_KEEP = COEF_W - FRAC_BITS;
    localparam int HI_W     = NUM_W - LOW_KEEP;
    localparam int REM_W    = DEN_W;
    localparam int QR_W     = COEF_W + 1;

    // Small constant multipliers of the closed-form numerators.
    localparam logic signed [3:0] K_LIN  = -4'sd6;
    localparam logic signed [2:0] K_QUAD = 3'sd3;
    localparam logic signed [2:0] K_CUBE = -3'sd2;

    // Saturation limits.
    localparam logic [COEF_W-1:0] POS_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
    localparam logic [COEF_W-1:0] NEG_MIN = {1'b1, {(COEF_W - 1){1'b0}}};

    // Lane order of the coefficients.
    localparam int LANE_CONST = 0;
    localparam int LANE_LIN   = 1;
    localparam int LANE_QUAD  = 2;
    localparam int LANE_CUBE  = 3;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SINGULAR = 2'd1,
        STATUS_SAT      = 2'd2
    } fecc_status_t;

    // One division lane: partial remainder and the shifting dividend/quotient word.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [COEF_W-1:0] word;
    } fecc_lane_t;

    // Everything a divider cell hands to its neighbor.
    typedef struct packed {
        logic                  valid;
        logic                  singular;
        logic [DEN_W-1:0]      den;
        logic [LANES-1:0]      neg;
        logic [LANES-1:0]      ovf;
        fecc_lane_t [LANES-1:0] lane;
    } fecc_cell_t;

endpackage

`default_nettype wire

FILE: rtl/core/fecc_front.sv
// Numerator and denominator pipeline of the flat-end cubic coefficient solver.
// Depends on fecc_pkg; feeds the first divider cell.
`default_nettype none

module fecc_front
    import fecc_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_take,
    input  wire logic signed [COORD_BITS-1:0] x_start,
    input  wire logic signed [COORD_BITS-1:0] y_start,
    input  wire logic signed [COORD_BITS-1:0] x_end,
    input  wire logic signed [COORD_BITS-1:0] y_end,
    output fecc_cell_t                        head
);

    // Stage valid bits.
    logic [5:0] v_reg;

    // Recovers x_end from the sum and x_start.
    function automatic logic signed [COORD_BITS-1:0] x_end_hold(
        input logic signed [COORD_BITS-1:0] x0,
        input logic signed [DIFF_W-1:0]     sm
    );
        logic signed [DIFF_W-1:0] diff;
        diff = sm - DIFF_W'(x0);
        return diff[COORD_BITS-1:0];
    endfunction

    // Stage 1: differences and sums.
    logic signed [COORD_BITS-1:0] x0_s1_reg, y0_s1_reg;
    logic signed [DIFF_W-1:0]     d_s1_reg, dy_s1_reg, sm_s1_reg;
    logic signed [TRI_W-1:0]      t_s1_reg;
    logic signed [DIFF_W-1:0]     d_s1_next, dy_s1_next, sm_s1_next;
    logic signed [TRI_W-1:0]      t_s1_next;

    always_comb
    begin
        d_s1_next  = DIFF_W'(x_end) - DIFF_W'(x_start);
        dy_s1_next = DIFF_W'(y_end) - DIFF_W'(y_start);
        sm_s1_next = DIFF_W'(x_end) + DIFF_W'(x_start);
        t_s1_next  = (TRI_W'(x_end) <<< 1) + TRI_W'(x_end) - TRI_W'(x_start);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_s1_reg <= x_start;
            y0_s1_reg <= y_start;
            d_s1_reg  <= d_s1_next;
            dy_s1_reg <= dy_s1_next;
            sm_s1_reg <= sm_s1_next;
            t_s1_reg  <= t_s1_next;
        end
    end

    // Stage 2: first products, magnitude and sign of the x difference.
    logic signed [DSQ_W-1:0]      dsq_s2_reg, ds_s2_reg;
    logic signed [SQ_W-1:0]       xx_s2_reg, x0sq_s2_reg;
    logic [ABS_W-1:0]             ad_s2_reg;
    logic                         dneg_s2_reg, sing_s2_reg;
    logic signed [DIFF_W-1:0]     dy_s2_reg;
    logic signed [TRI_W-1:0]      t_s2_reg;
    logic signed [COORD_BITS-1:0] y0_s2_reg;
    logic signed [DIFF_W-1:0]     dneg_val;

    assign dneg_val = -d_s1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsq_s2_reg  <= DSQ_W'(d_s1_reg) * DSQ_W'(d_s1_reg);
            ds_s2_reg   <= DSQ_W'(dy_s1_reg) * DSQ_W'(sm_s1_reg);
            xx_s2_reg   <= SQ_W'(x0_s1_reg) * SQ_W'(x_end_hold(x0_s1_reg, sm_s1_reg));
            x0sq_s2_reg <= SQ_W'(x0_s1_reg) * SQ_W'(x0_s1_reg);
            ad_s2_reg   <= d_s1_reg[DIFF_W-1] ? dneg_val[ABS_W-1:0] : d_s1_reg[ABS_W-1:0];
            dneg_s2_reg <= d_s1_reg[DIFF_W-1];
            sing_s2_reg <= (d_s1_reg == '0);
            dy_s2_reg   <= dy_s1_reg;
            t_s2_reg    <= t_s1_reg;
            y0_s2_reg   <= y0_s1_reg;
        end
    end

    // Stage 3: cube of the distance and products with the y difference.
    logic [DEN_W-1:0]             den_s3_reg;
    logic signed [PROD_W-1:0]     dxx_s3_reg, dx0sq_s3_reg;
    logic signed [DSQ_W-1:0]      ds_s3_reg;
    logic signed [DIFF_W-1:0]     dy_s3_reg;
    logic signed [TRI_W-1:0]      t_s3_reg;
    logic signed [COORD_BITS-1:0] y0_s3_reg;
    logic                         dneg_s3_reg, sing_s3_reg;
    logic [SQ_W-1:0]              dsq_mag;

    assign dsq_mag = dsq_s2_reg[SQ_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_s3_reg   <= DEN_W'(dsq_mag) * DEN_W'(ad_s2_reg);
            dxx_s3_reg   <= PROD_W'(dy_s2_reg) * PROD_W'(xx_s2_reg);
            dx0sq_s3_reg <= PROD_W'(dy_s2_reg) * PROD_W'(x0sq_s2_reg);
            ds_s3_reg    <= ds_s2_reg;
            dy_s3_reg    <= dy_s2_reg;
            t_s3_reg     <= t_s2_reg;
            y0_s3_reg    <= y0_s2_reg;
            dneg_s3_reg  <= dneg_s2_reg;
            sing_s3_reg  <= sing_s2_reg;
        end
    end

    // Stage 4: the four numerators, constant term still split in two.
    // Operands are widened first so that each product keeps all of its bits.
    logic signed [NUM_W-1:0] n0a_s4_reg, n1_s4_reg, n2_s4_reg, n3_s4_reg;
    logic signed [YD_W-1:0]  yd_s4_reg;
    logic [DEN_W-1:0]        den_s4_reg;
    logic                    dneg_s4_reg, sing_s4_reg;
    logic signed [DEN_W:0]   den_signed;

    assign den_signed = $signed({1'b0, den_s3_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0a_s4_reg  <= NUM_W'(dx0sq_s3_reg) * NUM_W'(t_s3_reg);
            yd_s4_reg   <= YD_W'(y0_s3_reg) * YD_W'(den_signed);
            n1_s4_reg   <= NUM_W'(dxx_s3_reg) * NUM_W'(K_LIN);
            n2_s4_reg   <= NUM_W'(ds_s3_reg) * NUM_W'(K_QUAD);
            n3_s4_reg   <= NUM_W'(dy_s3_reg) * NUM_W'(K_CUBE);
            den_s4_reg  <= den_s3_reg;
            dneg_s4_reg <= dneg_s3_reg;
            sing_s4_reg <= sing_s3_reg;
        end
    end

    // Stage 5: add the y_start term; the signed cube is minus den for a negative distance.
    logic signed [NUM_W-1:0] num_s5_reg [LANES];
    logic [DEN_W-1:0]        den_s5_reg;
    logic                    dneg_s5_reg, sing_s5_reg;
    logic signed [NUM_W-1:0] yd_ext;

    assign yd_ext = NUM_W'(yd_s4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_s5_reg[LANE_CONST] <= dneg_s4_reg ? (n0a_s4_reg - yd_ext)
                                                  : (n0a_s4_reg + yd_ext);
            num_s5_reg[LANE_LIN]   <= n1_s4_reg;
            num_s5_reg[LANE_QUAD]  <= n2_s4_reg;
            num_s5_reg[LANE_CUBE]  <= n3_s4_reg;
            den_s5_reg  <= den_s4_reg;
            dneg_s5_reg <= dneg_s4_reg;
            sing_s5_reg <= sing_s4_reg;
        end
    end

    // Stage 6: magnitudes and result signs.
    logic [NUM_W-1:0] mag_s6_reg [LANES];
    logic [LANES-1:0] neg_s6_reg;
    logic [DEN_W-1:0] den_s6_reg;
    logic             sing_s6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                mag_s6_reg[i] <= num_s5_reg[i][NUM_W-1] ? NUM_W'(-num_s5_reg[i])
                                                        : NUM_W'(num_s5_reg[i]);
                neg_s6_reg[i] <= num_s5_reg[i][NUM_W-1] ^ dneg_s5_reg;
            end
            den_s6_reg  <= den_s5_reg;
            sing_s6_reg <= sing_s5_reg;
        end
    end

    // Stage 7: split the scaled dividend; high part at or above den means overflow.
    fecc_cell_t head_reg, head_next;
    logic       head_valid_reg;

    always_comb
    begin
        head_next          = head_reg;
        head_next.valid    = v_reg[5];
        head_next.singular = sing_s6_reg;
        head_next.den      = den_s6_reg;
        head_next.neg      = neg_s6_reg;
        for (int i = 0; i < LANES; i++)
        begin
            logic [HI_W-1:0] hi;
            hi = mag_s6_reg[i][NUM_W-1:LOW_KEEP];
            head_next.ovf[i]       = (NUM_W'(hi) >= NUM_W'(den_s6_reg));
            head_next.lane[i].rem  = REM_W'(hi);
            head_next.lane[i].word = {mag_s6_reg[i][LOW_KEEP-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            head_reg <= head_next;
        end
    end

    // Valid bits through the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= '0;
            head_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg          <= {v_reg[4:0], in_take};
            head_valid_reg <= head_next.valid;
        end
    end

    // The reset valid bit overrides the data copy.
    always_comb
    begin
        head       = head_reg;
        head.valid = head_valid_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/core/fecc_cell.sv
// One divider cell: one restoring quotient bit for each of the four lanes.
// Depends on fecc_pkg; cells are chained in the top level.
`default_nettype none

module fecc_cell
    import fecc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  fecc_cell_t cin,
    output fecc_cell_t cout
);

    fecc_cell_t cell_reg, cell_next;
    logic       valid_reg;

    // Shift in the next dividend bit, subtract den when it fits.
    always_comb
    begin
        cell_next = cin;
        for (int i = 0; i < LANES; i++)
        begin
            logic [REM_W:0] r;
            logic [REM_W:0] dw;
            logic           ge;
            r  = {cin.lane[i].rem, cin.lane[i].word[COEF_W-1]};
            dw = {1'b0, cin.den};
            ge = (r >= dw);
            if (ge)
            begin
                r = r - dw;
            end
            cell_next.lane[i].rem  = r[REM_W-1:0];
            cell_next.lane[i].word = {cin.lane[i].word[COEF_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= cell_next.valid;
        end
    end

    // The reset valid bit overrides the data copy.
    always_comb
    begin
        cout       = cell_reg;
        cout.valid = valid_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/core/fecc_back.sv
// Rounding, saturation and output register of the flat-end cubic coefficient solver.
// Depends on fecc_pkg; takes the record leaving the last divider cell.
`default_nettype none

module fecc_back
    import fecc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  fecc_cell_t              tail,
    output logic                    out_valid,
    output logic signed [COEF_W-1:0] coef_const,
    output logic signed [COEF_W-1:0] coef_lin,
    output logic signed [COEF_W-1:0] coef_quad,
    output logic signed [COEF_W-1:0] coef_cube,
    output logic [1:0]              status
);

    // Round stage: add one when twice the remainder reaches den.
    logic             rv_reg;
    logic             rsing_reg;
    logic [LANES-1:0] rneg_reg, rovf_reg;
    logic [QR_W-1:0]  qr_reg [LANES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                qr_reg[i] <= {1'b0, tail.lane[i].word}
                           + QR_W'({tail.lane[i].rem, 1'b0} >= {1'b0, tail.den});
            end
            rsing_reg <= tail.singular;
            rneg_reg  <= tail.neg;
            rovf_reg  <= tail.ovf;
        end
    end

    // Saturate, apply the sign and pick the status.
    logic [COEF_W-1:0] coef_next [LANES];
    logic [LANES-1:0]  sat;
    fecc_status_t      status_next;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (rneg_reg[i])
            begin
                sat[i] = rovf_reg[i] || (qr_reg[i] > QR_W'(NEG_MIN));
            end
            else
            begin
                sat[i] = rovf_reg[i] || (qr_reg[i] > QR_W'(POS_MAX));
            end
            if (rsing_reg)
            begin
                coef_next[i] = '0;
            end
            else if (sat[i])
            begin
                coef_next[i] = rneg_reg[i] ? NEG_MIN : POS_MAX;
            end
            else
            begin
                coef_next[i] = rneg_reg[i] ? COEF_W'(-qr_reg[i]) : qr_reg[i][COEF_W-1:0];
            end
        end
        if (rsing_reg)
        begin
            status_next = STATUS_SINGULAR;
        end
        else if (sat != '0)
        begin
            status_next = STATUS_SAT;
        end
        else
        begin
            status_next = STATUS_OK;
        end
    end

    // Output register.
    logic              out_valid_reg;
    logic [COEF_W-1:0] coef_reg [LANES];
    fecc_status_t      status_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                coef_reg[i] <= coef_next[i];
            end
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rv_reg        <= tail.valid;
            out_valid_reg <= rv_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign coef_const = coef_reg[LANE_CONST];
    assign coef_lin   = coef_reg[LANE_LIN];
    assign coef_quad  = coef_reg[LANE_QUAD];
    assign coef_cube  = coef_reg[LANE_CUBE];
    assign status     = status_reg;

endmodule

`default_nettype wire

FILE: rtl/core/flat_end_cubic_coefficient_solver_core.sv
// Flat-end cubic coefficient solver. Each request carries two points and returns the
// four coefficients of the cubic through both with zero slope at each, in signed fixed
// point with 40 fraction bits, rounded to nearest with ties away from zero. Equal x
// values give zero coefficients and status 1; a coefficient out of the 64-bit range is
// saturated and gives status 2. One request is taken every cycle while the output does
// not stall. A result passes through seven register stages of numerator and
// denominator arithmetic, the first loaded at the edge that takes its request, a chain
// of 64 divider cells that each settle one quotient bit of all four coefficients, one
// rounding stage and the output register. A stall on the output holds the whole
// pipeline, so in_stall follows out_stall while a result waits.
// Depends on fecc_pkg, fecc_front, fecc_cell and fecc_back.
`default_nettype none

module flat_end_cubic_coefficient_solver_core
    import fecc_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [COORD_BITS-1:0] x_start,
    input  wire logic signed [COORD_BITS-1:0] y_start,
    input  wire logic signed [COORD_BITS-1:0] x_end,
    input  wire logic signed [COORD_BITS-1:0] y_end,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [COEF_W-1:0]          coef_const,
    output logic signed [COEF_W-1:0]          coef_lin,
    output logic signed [COEF_W-1:0]          coef_quad,
    output logic signed [COEF_W-1:0]          coef_cube,
    output logic [1:0]                        status
);

    // The pipeline moves unless a finished result is held by the receiver.
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    fecc_cell_t chain [CELLS + 1];

    fecc_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_take (in_valid),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .head    (chain[0])
    );

    // Divider chain, one quotient bit per cell.
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        fecc_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .cin   (chain[k]),
            .cout  (chain[k + 1])
        );
    end

    fecc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .tail       (chain[CELLS]),
        .out_valid  (out_valid),
        .coef_const (coef_const),
        .coef_lin   (coef_lin),
        .coef_quad  (coef_quad),
        .coef_cube  (coef_cube),
        .status     (status)
    );

endmodule

`default_nettype wire
